// ===== sv/gtfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtfr_pkg
// Shared types, codes and the 5x7 font for the glyph text renderer.
// ----------------------------------------------------------------------------
package gtfr_pkg;

   localparam int DEF_DISPLAY_WIDTH  = 128;
   localparam int DEF_DISPLAY_HEIGHT = 64;
   localparam int DEF_MAX_SCALE      = 4;

   localparam int CURSOR_W    = 12;
   localparam int CURSOR_MAX  = 4095;
   localparam int SCALE_W     = 4;
   localparam int GLYPH_COLS  = 5;
   localparam int GLYPH_ROWS  = 7;
   localparam int GLYPH_IDX_W = 6;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] REQ_CLEAR = 2'd0;
   localparam logic [1:0] REQ_DRAW  = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   typedef struct packed {
      logic [1:0]             kind;
      logic                   glyph_ok;
      logic [GLYPH_IDX_W-1:0] glyph_idx;
      logic [SCALE_W-1:0]     scale;
      logic [5:0]             top;
      logic [CURSOR_W-1:0]    x_start;
      logic [CURSOR_W-1:0]    cursor_x;
      logic [9:0]             read_index;
   } cmd_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   // Map a character to its font row; lowercase folds onto uppercase.
   function automatic logic [GLYPH_IDX_W:0] glyph_index(input logic [6:0] ch);
      logic [GLYPH_IDX_W:0] r;
      r = '0;
      if (ch >= 7'h30 && ch <= 7'h39)
         r = {1'b1, GLYPH_IDX_W'(ch - 7'h30 + 7'd4)};
      else if (ch >= 7'h41 && ch <= 7'h5A)
         r = {1'b1, GLYPH_IDX_W'(ch - 7'h41 + 7'd14)};
      else if (ch >= 7'h61 && ch <= 7'h7A)
         r = {1'b1, GLYPH_IDX_W'(ch - 7'h61 + 7'd14)};
      else begin
         case (ch)
            7'h20:   r = {1'b1, 6'd0};
            7'h21:   r = {1'b1, 6'd1};
            7'h22:   r = {1'b1, 6'd2};
            7'h23:   r = {1'b1, 6'd3};
            7'h2D:   r = {1'b1, 6'd40};
            7'h2E:   r = {1'b1, 6'd41};
            7'h3A:   r = {1'b1, 6'd42};
            7'h3F:   r = {1'b1, 6'd43};
            default: r = '0;
         endcase
      end
      return r;
   endfunction

   // Font row: column 0 in bits [7:0], bit r of a column is glyph row r.
   function automatic logic [39:0] glyph_bits(input logic [GLYPH_IDX_W-1:0] idx);
      logic [39:0] g;
      case (idx)
         6'd0:    g = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
         6'd1:    g = {8'h00, 8'h00, 8'h5F, 8'h00, 8'h00};
         6'd2:    g = {8'h00, 8'h07, 8'h00, 8'h07, 8'h00};
         6'd3:    g = {8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14};
         6'd4:    g = {8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E};
         6'd5:    g = {8'h00, 8'h40, 8'h7F, 8'h42, 8'h00};
         6'd6:    g = {8'h46, 8'h49, 8'h51, 8'h61, 8'h42};
         6'd7:    g = {8'h31, 8'h4B, 8'h45, 8'h41, 8'h21};
         6'd8:    g = {8'h10, 8'h7F, 8'h12, 8'h14, 8'h18};
         6'd9:    g = {8'h39, 8'h45, 8'h45, 8'h45, 8'h27};
         6'd10:   g = {8'h30, 8'h49, 8'h49, 8'h4A, 8'h3C};
         6'd11:   g = {8'h03, 8'h05, 8'h09, 8'h71, 8'h01};
         6'd12:   g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
         6'd13:   g = {8'h1E, 8'h29, 8'h49, 8'h49, 8'h06};
         6'd14:   g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
         6'd15:   g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h7F};
         6'd16:   g = {8'h22, 8'h41, 8'h41, 8'h41, 8'h3E};
         6'd17:   g = {8'h1C, 8'h22, 8'h41, 8'h41, 8'h7F};
         6'd18:   g = {8'h41, 8'h49, 8'h49, 8'h49, 8'h7F};
         6'd19:   g = {8'h01, 8'h09, 8'h09, 8'h09, 8'h7F};
         6'd20:   g = {8'h7A, 8'h49, 8'h49, 8'h41, 8'h3E};
         6'd21:   g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
         6'd22:   g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
         6'd23:   g = {8'h01, 8'h3F, 8'h41, 8'h40, 8'h20};
         6'd24:   g = {8'h41, 8'h22, 8'h14, 8'h08, 8'h7F};
         6'd25:   g = {8'h40, 8'h40, 8'h40, 8'h40, 8'h7F};
         6'd26:   g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
         6'd27:   g = {8'h7F, 8'h10, 8'h08, 8'h04, 8'h7F};
         6'd28:   g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
         6'd29:   g = {8'h06, 8'h09, 8'h09, 8'h09, 8'h7F};
         6'd30:   g = {8'h5E, 8'h21, 8'h51, 8'h41, 8'h3E};
         6'd31:   g = {8'h46, 8'h29, 8'h19, 8'h09, 8'h7F};
         6'd32:   g = {8'h31, 8'h49, 8'h49, 8'h49, 8'h46};
         6'd33:   g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
         6'd34:   g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
         6'd35:   g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
         6'd36:   g = {8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F};
         6'd37:   g = {8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
         6'd38:   g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
         6'd39:   g = {8'h43, 8'h45, 8'h49, 8'h51, 8'h61};
         6'd40:   g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
         6'd41:   g = {8'h00, 8'h00, 8'h60, 8'h60, 8'h00};
         6'd42:   g = {8'h00, 8'h00, 8'h36, 8'h36, 8'h00};
         6'd43:   g = {8'h06, 8'h09, 8'h51, 8'h01, 8'h02};
         default: g = '0;
      endcase
      return g;
   endfunction

endpackage

// ===== sv/gtfr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtfr_front
// Accepts requests, clamps scale, looks up the glyph and tracks the cursor.
// ----------------------------------------------------------------------------
module gtfr_front #(
   parameter int MAX_SCALE = gtfr_pkg::DEF_MAX_SCALE
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [1:0]               req_type,
   input  logic [6:0]               char_code,
   input  logic [6:0]               pos_x,
   input  logic [5:0]               pos_y,
   input  logic                     new_string,
   input  logic [2:0]               scale,
   input  logic [9:0]               read_index,
   input  logic                     queue_full,
   input  gtfr_pkg::back_status_type back_status,
   output logic                     push,
   output gtfr_pkg::cmd_type        push_cmd
);

   logic [gtfr_pkg::CURSOR_W-1:0]    cursor_ff, cursor_in;
   logic [gtfr_pkg::SCALE_W-1:0]     s_eff;
   logic [gtfr_pkg::CURSOR_W-1:0]    x_start;
   logic [gtfr_pkg::CURSOR_W:0]      sum;
   logic [gtfr_pkg::CURSOR_W-1:0]    adv;
   logic [gtfr_pkg::GLYPH_IDX_W:0]   gi;

   assign req_tready = !queue_full && !back_status.clearing;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      if (scale == 3'd0)
         s_eff = gtfr_pkg::SCALE_W'(1);
      else if (32'(scale) > MAX_SCALE)
         s_eff = gtfr_pkg::SCALE_W'(MAX_SCALE);
      else
         s_eff = gtfr_pkg::SCALE_W'(scale);
      x_start = new_string ? gtfr_pkg::CURSOR_W'(pos_x) : cursor_ff;
      sum = (gtfr_pkg::CURSOR_W+1)'(x_start) + (gtfr_pkg::CURSOR_W+1)'(s_eff) * 13'd6;
      adv = (sum > (gtfr_pkg::CURSOR_W+1)'(gtfr_pkg::CURSOR_MAX))
            ? gtfr_pkg::CURSOR_W'(gtfr_pkg::CURSOR_MAX) : sum[gtfr_pkg::CURSOR_W-1:0];
      gi = gtfr_pkg::glyph_index(char_code);
      cursor_in = (push && req_type == gtfr_pkg::REQ_DRAW) ? adv : cursor_ff;

      push_cmd.kind       = req_type;
      push_cmd.glyph_ok   = gi[gtfr_pkg::GLYPH_IDX_W];
      push_cmd.glyph_idx  = gi[gtfr_pkg::GLYPH_IDX_W-1:0];
      push_cmd.scale      = s_eff;
      push_cmd.top        = pos_y;
      push_cmd.x_start    = x_start;
      push_cmd.cursor_x   = cursor_in;
      push_cmd.read_index = read_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
      end else begin
         cursor_ff <= cursor_in;
      end
   end

endmodule

// ===== sv/gtfr_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtfr_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module gtfr_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gtfr_pkg::cmd_type push_cmd,
   input  logic              pop,
   output gtfr_pkg::cmd_type head,
   output logic              empty,
   output logic              full
);

   localparam int PTR_W = (gtfr_pkg::QUEUE_DEPTH > 1) ? $clog2(gtfr_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(gtfr_pkg::QUEUE_DEPTH + 1);

   gtfr_pkg::cmd_type slot_ff [gtfr_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(gtfr_pkg::QUEUE_DEPTH));
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == gtfr_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == gtfr_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== sv/gtfr_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtfr_back
// Runs commands on the frame store: clear sweep, glyph draw by page
// read-modify-write, and byte read; holds the response register.
// ----------------------------------------------------------------------------
module gtfr_back #(
   parameter int DISPLAY_WIDTH  = gtfr_pkg::DEF_DISPLAY_WIDTH,
   parameter int DISPLAY_HEIGHT = gtfr_pkg::DEF_DISPLAY_HEIGHT,
   parameter int MAX_SCALE      = gtfr_pkg::DEF_MAX_SCALE
) (
   input  logic                      clock,
   input  logic                      reset,
   input  gtfr_pkg::cmd_type         head,
   input  logic                      empty,
   output logic                      pop,
   output gtfr_pkg::back_status_type back_status,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_read_data,
   output logic [gtfr_pkg::CURSOR_W-1:0] rsp_cursor_x
);

   localparam int PAGES   = (DISPLAY_HEIGHT + 7) / 8;
   localparam int STORE   = DISPLAY_WIDTH * PAGES;
   localparam int ADDR_W  = $clog2(STORE);
   localparam int EXP_W   = 7 * MAX_SCALE;
   localparam int IMG_W   = 128 + EXP_W;
   localparam int XW      = gtfr_pkg::CURSOR_W + 1;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_COL   = 3'd2;
   localparam logic [2:0] ST_RD    = 3'd3;
   localparam logic [2:0] ST_WR    = 3'd4;
   localparam logic [2:0] ST_RDX   = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [7:0]               mem [STORE];

   logic [2:0]               state_ff, state_in;
   logic                     init_ff, init_in;
   logic [ADDR_W-1:0]        clr_ff, clr_in;
   gtfr_pkg::cmd_type        cmd_ff, cmd_in;
   logic [XW-1:0]            x_ff, x_in;
   logic [2:0]               col_ff, col_in;
   logic [gtfr_pkg::SCALE_W-1:0] dx_ff, dx_in;
   logic [4:0]               page_ff, page_in, page_end_ff, page_end_in;
   logic [IMG_W-1:0]         img_ff, img_in;
   logic [7:0]               rd_data_ff;
   logic                     rd_ok_ff, rd_ok_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_data_ff, rsp_data_in;
   logic [gtfr_pkg::CURSOR_W-1:0] rsp_cur_ff, rsp_cur_in;

   logic                     we, re;
   logic [ADDR_W-1:0]        waddr, raddr, draw_addr;
   logic [7:0]               wdata, row_mask;
   logic [7:0]               head_end;
   logic [4:0]               head_pstart, head_pend;
   logic [EXP_W-1:0]         expd;
   logic [7:0]               col_bits;
   logic [39:0]              gbits;
   logic                     ri_ok;

   assign back_status.clearing = init_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_cursor_x  = rsp_cur_ff;

   always_comb begin
      head_end    = 8'(head.top) + 8'(head.scale) * 8'd7 - 8'd1;
      head_pstart = 5'(head.top >> 3);
      head_pend   = (32'(head_end >> 3) > PAGES - 1) ? 5'(PAGES - 1) : 5'(head_end >> 3);

      // Stretch the current glyph column vertically by the scale.
      gbits    = gtfr_pkg::glyph_bits(cmd_ff.glyph_idx);
      col_bits = gbits[col_ff*8 +: 8];
      expd = '0;
      for (int r = 0; r < gtfr_pkg::GLYPH_ROWS; r++) begin
         for (int k = 0; k < MAX_SCALE; k++) begin
            if (k < 32'(cmd_ff.scale))
               expd[r * 32'(cmd_ff.scale) + k] = col_bits[r];
         end
      end

      for (int b = 0; b < 8; b++) begin
         row_mask[b] = (32'(page_ff) * 8 + b) < DISPLAY_HEIGHT;
      end

      draw_addr = ADDR_W'(x_ff) + ADDR_W'(32'(page_ff) * DISPLAY_WIDTH);
      ri_ok     = 32'(cmd_ff.read_index) < STORE;
   end

   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      clr_in       = clr_ff;
      cmd_in       = cmd_ff;
      x_in         = x_ff;
      col_in       = col_ff;
      dx_in        = dx_ff;
      page_in      = page_ff;
      page_end_in  = page_end_ff;
      img_in       = img_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      rsp_cur_in   = rsp_cur_ff;
      pop   = 1'b0;
      we    = 1'b0;
      re    = 1'b0;
      waddr = draw_addr;
      raddr = draw_addr;
      wdata = rd_data_ff | (img_ff[32'(page_ff) * 8 +: 8] & row_mask);

      unique case (state_ff)
         ST_CLEAR: begin
            we    = 1'b1;
            waddr = clr_ff;
            wdata = '0;
            if (32'(clr_ff) == STORE - 1) begin
               clr_in   = '0;
               init_in  = 1'b0;
               state_in = init_ff ? ST_IDLE : ST_DONE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (!empty) begin
               pop         = 1'b1;
               cmd_in      = head;
               x_in        = XW'(head.x_start);
               col_in      = '0;
               dx_in       = '0;
               page_end_in = head_pend;
               rd_ok_in    = 1'b0;
               case (head.kind)
                  gtfr_pkg::REQ_CLEAR: state_in = ST_CLEAR;
                  gtfr_pkg::REQ_DRAW:
                     state_in = (head.glyph_ok && head_pstart <= head_pend) ? ST_COL : ST_DONE;
                  gtfr_pkg::REQ_READ:  state_in = ST_RDX;
                  default:             state_in = ST_DONE;
               endcase
            end
         end
         ST_COL: begin
            if (32'(col_ff) == gtfr_pkg::GLYPH_COLS || x_ff >= XW'(DISPLAY_WIDTH)) begin
               state_in = ST_DONE;
            end else begin
               img_in   = IMG_W'(expd) << cmd_ff.top;
               page_in  = 5'(cmd_ff.top >> 3);
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            re       = 1'b1;
            state_in = ST_WR;
         end
         ST_WR: begin
            we = 1'b1;
            if (page_ff == page_end_ff) begin
               x_in = x_ff + 1'b1;
               if (dx_ff == cmd_ff.scale - 1'b1) begin
                  dx_in  = '0;
                  col_in = col_ff + 1'b1;
               end else begin
                  dx_in = dx_ff + 1'b1;
               end
               state_in = ST_COL;
            end else begin
               page_in  = page_ff + 1'b1;
               state_in = ST_RD;
            end
         end
         ST_RDX: begin
            re       = ri_ok;
            raddr    = ADDR_W'(cmd_ff.read_index);
            rd_ok_in = ri_ok;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = (cmd_ff.kind == gtfr_pkg::REQ_READ && rd_ok_ff) ? rd_data_ff : '0;
               rsp_cur_in   = cmd_ff.cursor_x;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         init_ff      <= 1'b1;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      x_ff        <= x_in;
      col_ff      <= col_in;
      dx_ff       <= dx_in;
      page_ff     <= page_in;
      page_end_ff <= page_end_in;
      img_ff      <= img_in;
      rd_ok_ff    <= rd_ok_in;
      rsp_data_ff <= rsp_data_in;
      rsp_cur_ff  <= rsp_cur_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= mem[raddr];
      end
   end

endmodule

// ===== sv/glyph_text_framebuffer_renderer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_text_framebuffer_renderer
// Page-organized monochrome frame store with a 5x7 text renderer.
// ----------------------------------------------------------------------------
// Each request gives one response. A draw walks the 5*scale pixel columns
// of the glyph and does a read-modify-write (a read state, then a write
// state) on every store page the cell touches, with one column setup state
// for each column; clipped columns and unknown characters end early. A
// clear sweeps the store one byte per cycle (1024 bytes at the default
// size). After reset the same sweep runs and no request is accepted until
// it ends.
// ----------------------------------------------------------------------------
module glyph_text_framebuffer_renderer #(
   parameter int DISPLAY_WIDTH  = gtfr_pkg::DEF_DISPLAY_WIDTH,
   parameter int DISPLAY_HEIGHT = gtfr_pkg::DEF_DISPLAY_HEIGHT,
   parameter int MAX_SCALE      = gtfr_pkg::DEF_MAX_SCALE
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // char_code[6:0], pos_x[13:7], pos_y[19:14], new_string[20], scale[23:21],
   // read_index[33:24], zero fill
   input  logic [39:0] req_tdata,
   // req_type[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[7:0], cursor_x[19:8], zero fill
   output logic [23:0] rsp_tdata
);

   gtfr_pkg::cmd_type         push_cmd, head;
   gtfr_pkg::back_status_type back_status;
   logic                      push, pop, empty, full;
   logic [7:0]                read_data;
   logic [gtfr_pkg::CURSOR_W-1:0] cursor_x;

   gtfr_front #(.MAX_SCALE(MAX_SCALE)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_type    (req_tuser),
      .char_code   (req_tdata[6:0]),
      .pos_x       (req_tdata[13:7]),
      .pos_y       (req_tdata[19:14]),
      .new_string  (req_tdata[20]),
      .scale       (req_tdata[23:21]),
      .read_index  (req_tdata[33:24]),
      .queue_full  (full),
      .back_status (back_status),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   gtfr_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .empty    (empty),
      .full     (full)
   );

   gtfr_back #(
      .DISPLAY_WIDTH  (DISPLAY_WIDTH),
      .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
      .MAX_SCALE      (MAX_SCALE)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .empty         (empty),
      .pop           (pop),
      .back_status   (back_status),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_read_data (read_data),
      .rsp_cursor_x  (cursor_x)
   );

   assign rsp_tdata = {4'b0, cursor_x, read_data};

`ifndef SYNTHESIS
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      back_status.clearing |-> !req_tready)
      else $error("request accepted during power-up clear");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue popped while empty");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue pushed while full");
`endif

endmodule
